// ----- sv/mfma_pkg.sv -----
// Shared types and constants for the minifloat multiply/add unit.
package mfma_pkg;

    localparam int WORD_W   = 14;
    localparam int EXP_W    = 5;
    localparam int FRAC_W   = 9;
    localparam int MANT_W   = FRAC_W + 1;
    localparam int PROD_W   = 2 * MANT_W;
    localparam int ECALC_W  = EXP_W + 2;

    localparam int EXP_BIAS = 15;
    localparam int EXP_MAX  = 30;

    localparam logic [EXP_W-1:0] EXP_SPECIAL = '1;
    localparam logic [EXP_W-1:0] EXP_ZERO    = '0;

    typedef enum logic [0:0] {
        FUNC_MUL = 1'b0,
        FUNC_ADD = 1'b1
    } func_t;

endpackage

// ----- sv/minifloat_multiply_add.sv -----
// Top level of the minifloat multiply/add unit: input register, datapath, result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------
//  input   | in_valid  | in_stall  | func, operand_a, operand_b
//  output  | out_valid | out_stall | result_code, overflow
//
// Each beat is loaded into the input register and then into the result
// register after a single combinational pass (one 10x10 multiplier or one
// aligning shift and 11-bit add).
// A new beat is taken every cycle while the output drains; throughput is one
// beat per cycle.
// Reset clears both valid flags; payload registers keep whatever they hold.
// A stall on the output holds the result; the input register still takes one
// more beat and then the input stalls until the result is taken.
module minifloat_multiply_add
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [mfma_pkg::WORD_W-1:0]   operand_a,
    input  logic [mfma_pkg::WORD_W-1:0]   operand_b,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mfma_pkg::WORD_W-1:0]   result_code,
    output logic                          overflow
);

    localparam int EW = mfma_pkg::EXP_W;
    localparam int FW = mfma_pkg::FRAC_W;
    localparam int MW = mfma_pkg::MANT_W;
    localparam int PW = mfma_pkg::PROD_W;
    localparam int CW = mfma_pkg::ECALC_W;

    // Input register.
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    mfma_pkg::func_t             func_reg;
    logic [mfma_pkg::WORD_W-1:0] a_reg;
    logic [mfma_pkg::WORD_W-1:0] b_reg;

    // Result register.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [mfma_pkg::WORD_W-1:0] result_code_reg;
    logic [mfma_pkg::WORD_W-1:0] result_code_next;
    logic                        overflow_reg;
    logic                        overflow_next;

    logic                        in_take;
    logic                        advance;

    // Datapath signals.
    logic [EW-1:0]               ea;
    logic [EW-1:0]               eb;
    logic [EW-1:0]               eh;
    logic [EW-1:0]               shift_d;
    logic [MW-1:0]               ma;
    logic [MW-1:0]               mb;
    logic [MW-1:0]               big;
    logic [MW-1:0]               small_m;
    logic [PW-1:0]               prod;
    logic [MW:0]                 sum;
    logic signed [CW-1:0]        e_res;
    logic [FW-1:0]               frac;

    // Advance the input register into the result register when the result
    // register is empty or is handing its beat off this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Single-pass arithmetic on the input register.
    always_comb
    begin
        ea      = a_reg[FW +: EW];
        eb      = b_reg[FW +: EW];
        ma      = {1'b1, a_reg[FW-1:0]};
        mb      = {1'b1, b_reg[FW-1:0]};
        prod    = PW'(ma) * PW'(mb);

        // Align the operand with the smaller exponent; truncation of the
        // shifted-out bits matches truncation of the exact sum.
        if (ea >= eb)
        begin
            eh      = ea;
            shift_d = ea - eb;
            big     = ma;
            small_m = mb;
        end
        else
        begin
            eh      = eb;
            shift_d = eb - ea;
            big     = mb;
            small_m = ma;
        end
        sum = {1'b0, big} + {1'b0, small_m >> shift_d};

        case (func_reg)
            mfma_pkg::FUNC_MUL:
            begin
                e_res = $signed(CW'(ea) + CW'(eb) - CW'(mfma_pkg::EXP_BIAS)
                                + CW'(prod[PW-1]));
                frac  = prod[PW-1] ? prod[PW-2 -: FW] : prod[PW-3 -: FW];
            end
            mfma_pkg::FUNC_ADD:
            begin
                e_res = $signed(CW'(eh) + CW'(sum[MW]));
                frac  = sum[MW] ? sum[MW-1 -: FW] : sum[FW-1:0];
            end
            default:
            begin
                e_res = '0;
                frac  = '0;
            end
        endcase

        // Operand checks first (a before b), then range of the result exponent.
        result_code_next = '0;
        overflow_next    = 1'b0;
        if (ea == mfma_pkg::EXP_SPECIAL)
        begin
            overflow_next = 1'b1;
        end
        else if (ea == mfma_pkg::EXP_ZERO)
        begin
            overflow_next = 1'b0;
        end
        else if (eb == mfma_pkg::EXP_SPECIAL)
        begin
            overflow_next = 1'b1;
        end
        else if (eb == mfma_pkg::EXP_ZERO)
        begin
            overflow_next = 1'b0;
        end
        else if (e_res > $signed(CW'(mfma_pkg::EXP_MAX)))
        begin
            overflow_next = 1'b1;
        end
        else if (e_res >= $signed(CW'(1)))
        begin
            result_code_next = {e_res[EW-1:0], frac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= mfma_pkg::func_t'(func);
            a_reg    <= operand_a;
            b_reg    <= operand_b;
        end
        if (advance)
        begin
            result_code_reg <= result_code_next;
            overflow_reg    <= overflow_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_code = result_code_reg;
    assign overflow    = overflow_reg;

    // A beat moved out of the input register shows up as a valid result.
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat did not reach the result register");

    // A taken input beat sits in the input register on the next cycle.
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted beat lost from the input register");

    // Both registers full and the output stalled: the input must stall.
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("input taken while pipeline is full");

    // An overflowed result always carries a zero code.
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && overflow_reg) |-> (result_code_reg == '0))
        else $error("overflow with nonzero result code");

endmodule
